/* design/spq_pkg.sv */
package spq_pkg;

  // Operation codes of an input item
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_PRIO = 2'd3;

  // Priority levels 1 to 3; 0 marks no entry / invalid priority
  localparam int unsigned NUM_LEVELS = 3;
  localparam logic [1:0]  PRIO_NONE  = 2'd0;

  // Widths fixed by the result fields
  localparam int unsigned OUT_TAG_BITS = 8;
  localparam int unsigned OCC_BITS     = 5;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_t;

endpackage

/* design/sorted_priority_queue_top.sv */
// Sorted priority queue with up to CAPACITY entries, priorities 1 (low) to 3 (high).
// Input channel (in_valid/in_ready): operation 0 enqueues priority_req/tag,
// operation 1 dequeues the head entry. Result channel (out_valid/out_ready):
// status, removed entry (out_priority/out_tag, zero when nothing is removed)
// and the occupancy after the operation. Exactly one result per item.
// Entries are held in one tag memory split into one circular deque per
// priority level; the level itself is the stored priority. An enqueue at or
// above the highest level present pushes to the front of its level, otherwise
// to the back; a dequeue pops the front of the highest non-empty level.
// Sequence: an item is accepted in S_IDLE, where the head is read from the
// tag memory into rd_tag and the pending result is registered; in S_RESULT
// the output register is loaded from them. The registered read of the tag
// memory sets this sequence; the next item is accepted as soon as the result
// is registered, while that result may still wait at the output.
// A stalled receiver holds the result in the output register; the block then
// holds its pending result and takes no further item until the output frees.
// Reset (rst, synchronous) empties the queue; memory contents need no clearing.
module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [1:0]                         priority_req,
  input  logic [TAG_BITS-1:0]                tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [1:0]                         out_priority,
  output logic [spq_pkg::OUT_TAG_BITS-1:0]   out_tag,
  output logic [spq_pkg::OCC_BITS-1:0]       occupancy
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned PTR_W  = $clog2(CAPACITY);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned DEPTH  = spq_pkg::NUM_LEVELS * CAPACITY;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] CAP_A    = ADDR_W'(CAPACITY);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(CAPACITY - 1);
  localparam logic [SUM_W-1:0]  CAP_S    = SUM_W'(CAPACITY);

  // Tag memory, one region of CAPACITY slots per priority level
  logic [TAG_BITS-1:0] mem [DEPTH];
  logic [TAG_BITS-1:0] rd_tag;

  // Per-level deque pointers and counts, total fill
  logic [PTR_W-1:0] head      [spq_pkg::NUM_LEVELS];
  logic [CNT_W-1:0] cnt       [spq_pkg::NUM_LEVELS];
  logic [PTR_W-1:0] head_next [spq_pkg::NUM_LEVELS];
  logic [CNT_W-1:0] cnt_next  [spq_pkg::NUM_LEVELS];
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;

  spq_pkg::state_t state;

  // Pending result between accept and output
  logic [1:0]       pend_status;
  logic [1:0]       pend_prio;
  logic [CNT_W-1:0] pend_occ;
  logic             pend_deq_ok;

  // Decode of the current item
  logic             accept;
  logic             out_load;
  logic [1:0]       max_lvl;
  logic             do_front;
  logic             do_back;
  logic             do_deq;
  logic [1:0]       st;
  logic [PTR_W-1:0] enq_head;
  logic [CNT_W-1:0] enq_cnt;
  logic [PTR_W-1:0] deq_head;
  logic [PTR_W-1:0] front_slot;
  logic [SUM_W-1:0] back_sum;
  logic [PTR_W-1:0] back_slot;
  logic [PTR_W-1:0] wr_slot;
  logic [1:0]       enq_idx;
  logic [1:0]       deq_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [TAG_BITS+spq_pkg::OUT_TAG_BITS-1:0] tag_ext;
  logic [CNT_W+spq_pkg::OCC_BITS-1:0]        occ_ext;

  assign in_ready = (state == spq_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == spq_pkg::S_RESULT) && (!out_valid || out_ready);

  // Find the highest level present and select the pointers in use
  always_comb begin
    max_lvl  = spq_pkg::PRIO_NONE;
    enq_head = '0;
    enq_cnt  = '0;
    deq_head = '0;
    for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
      if (cnt[i] != '0) begin
        max_lvl = 2'(i + 1);
      end
    end
    for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
      if (priority_req == 2'(i + 1)) begin
        enq_head = head[i];
        enq_cnt  = cnt[i];
      end
      if (max_lvl == 2'(i + 1)) begin
        deq_head = head[i];
      end
    end
  end

  // Classify the item and compute slots
  always_comb begin
    do_front = 1'b0;
    do_back  = 1'b0;
    do_deq   = 1'b0;
    st       = spq_pkg::ST_OK;
    if (operation == spq_pkg::OP_DEQUEUE) begin
      if (fill == '0) begin
        st = spq_pkg::ST_EMPTY;
      end else begin
        do_deq = accept;
      end
    end else begin
      if (priority_req == spq_pkg::PRIO_NONE) begin
        st = spq_pkg::ST_BAD_PRIO;
      end else if (fill == CNT_W'(CAPACITY)) begin
        st = spq_pkg::ST_FULL;
      end else if (priority_req >= max_lvl) begin
        do_front = accept;
      end else begin
        do_back = accept;
      end
    end

    front_slot = (enq_head == '0) ? LAST_PTR : enq_head - 1'b1;
    back_sum   = SUM_W'(enq_head) + SUM_W'(enq_cnt);
    back_slot  = (back_sum >= CAP_S) ? PTR_W'(back_sum - CAP_S) : PTR_W'(back_sum);
    wr_slot    = do_front ? front_slot : back_slot;
    enq_idx    = priority_req - 2'd1;
    deq_idx    = max_lvl - 2'd1;
    wr_addr    = ADDR_W'(enq_idx) * CAP_A + ADDR_W'(wr_slot);
    rd_addr    = ADDR_W'(deq_idx) * CAP_A + ADDR_W'(deq_head);
  end

  // Advance the per-level pointers
  always_comb begin
    fill_next = fill;
    if (do_front || do_back) begin
      fill_next = fill + 1'b1;
    end else if (do_deq) begin
      fill_next = fill - 1'b1;
    end
    for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
      head_next[i] = head[i];
      cnt_next[i]  = cnt[i];
      if ((do_front || do_back) && priority_req == 2'(i + 1)) begin
        cnt_next[i] = cnt[i] + 1'b1;
        if (do_front) begin
          head_next[i] = front_slot;
        end
      end
      if (do_deq && max_lvl == 2'(i + 1)) begin
        cnt_next[i]  = cnt[i] - 1'b1;
        head_next[i] = (head[i] == LAST_PTR) ? '0 : head[i] + 1'b1;
      end
    end
  end

  // Memory: write new tag, read the head of the top level
  always_ff @(posedge clk) begin
    if (do_front || do_back) begin
      mem[wr_addr] <= tag;
    end
    if (accept) begin
      rd_tag <= mem[rd_addr];
    end
  end

  // Queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      fill <= fill_next;
      for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
        head[i] <= head_next[i];
        cnt[i]  <= cnt_next[i];
      end
    end
  end

  // Hold the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st;
      pend_prio   <= do_deq ? max_lvl : spq_pkg::PRIO_NONE;
      pend_occ    <= fill_next;
      pend_deq_ok <= do_deq;
    end
  end

  assign tag_ext = {{spq_pkg::OUT_TAG_BITS{1'b0}}, rd_tag};
  assign occ_ext = {{spq_pkg::OCC_BITS{1'b0}}, pend_occ};

  // Sequence accept and result, drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        spq_pkg::S_IDLE: begin
          if (accept) begin
            state <= spq_pkg::S_RESULT;
          end
        end
        spq_pkg::S_RESULT: begin
          if (out_load) begin
            state <= spq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= spq_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= pend_status;
      out_priority <= pend_prio;
      out_tag      <= pend_deq_ok ? tag_ext[spq_pkg::OUT_TAG_BITS-1:0] : '0;
      occupancy    <= occ_ext[spq_pkg::OCC_BITS-1:0];
    end
  end

endmodule

/* verif/sorted_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned TAG_BITS  = 8;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned MAX_CYCLES = 300000;
  localparam int unsigned MAX_REPORTS = 10;

  // Priority levels of a stored entry
  localparam logic [1:0] PRIO_LOW  = 2'd1;
  localparam logic [1:0] PRIO_MID  = 2'd2;
  localparam logic [1:0] PRIO_HIGH = 2'd3;

  typedef struct {
    logic                op;
    logic [1:0]          prio;
    logic [TAG_BITS-1:0] tg;
  } queue_req_t;

  typedef struct {
    logic [1:0]                       st;
    logic [1:0]                       prio;
    logic [spq_pkg::OUT_TAG_BITS-1:0] tg;
    logic [spq_pkg::OCC_BITS-1:0]     occ;
  } queue_resp_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             operation = spq_pkg::OP_ENQUEUE;
  logic [1:0]                       priority_req = spq_pkg::PRIO_NONE;
  logic [TAG_BITS-1:0]              tag = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [1:0]                       status;
  logic [1:0]                       out_priority;
  logic [spq_pkg::OUT_TAG_BITS-1:0] out_tag;
  logic [spq_pkg::OCC_BITS-1:0]     occupancy;

  sorted_priority_queue_top #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .priority_req(priority_req),
    .tag(tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_priority(out_priority),
    .out_tag(out_tag),
    .occupancy(occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be sent and results still owed by the block
  queue_req_t  pending_items[$];
  queue_resp_t results_due[$];

  // Shadow copy of the queue contents, head at slot 0
  logic [1:0]          shadow_prio[CAPACITY];
  logic [TAG_BITS-1:0] shadow_tag[CAPACITY];
  int unsigned         shadow_fill = 0;

  bit          idle_on = 1'b1;
  int unsigned holds_asked = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned bad_prio_hits = 0;
  int unsigned peak_fill = 0;
  int unsigned cycle_count = 0;

  // Apply one item to the shadow queue and return the result it must give
  function automatic queue_resp_t queue_step(queue_req_t r);
    queue_resp_t res;
    int unsigned pos;
    int unsigned i;
    res.st   = spq_pkg::ST_OK;
    res.prio = spq_pkg::PRIO_NONE;
    res.tg   = '0;
    if (r.op == spq_pkg::OP_DEQUEUE) begin
      if (shadow_fill == 0) begin
        res.st = spq_pkg::ST_EMPTY;
        empty_hits++;
      end else begin
        res.prio = shadow_prio[0];
        res.tg   = (spq_pkg::OUT_TAG_BITS)'(shadow_tag[0]);
        for (i = 1; i < shadow_fill; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_tag[i-1]  = shadow_tag[i];
        end
        shadow_fill--;
      end
    end else if (r.prio == spq_pkg::PRIO_NONE) begin
      res.st = spq_pkg::ST_BAD_PRIO;
      bad_prio_hits++;
    end else if (shadow_fill >= CAPACITY) begin
      res.st = spq_pkg::ST_FULL;
      full_hits++;
    end else begin
      // Find the slot: head if at least the head, else after the last equal-or-higher
      if (shadow_fill == 0 || r.prio >= shadow_prio[0]) begin
        pos = 0;
      end else begin
        pos = 1;
        while (pos < shadow_fill && shadow_prio[pos] >= r.prio) pos++;
      end
      for (i = shadow_fill; i > pos; i--) begin
        shadow_prio[i] = shadow_prio[i-1];
        shadow_tag[i]  = shadow_tag[i-1];
      end
      shadow_prio[pos] = r.prio;
      shadow_tag[pos]  = r.tg;
      shadow_fill++;
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    end
    res.occ = (spq_pkg::OCC_BITS)'(shadow_fill);
    return res;
  endfunction

  function automatic void add_item(logic op, logic [1:0] prio, logic [TAG_BITS-1:0] tg);
    queue_req_t r;
    r.op   = op;
    r.prio = prio;
    r.tg   = tg;
    pending_items.push_back(r);
  endfunction

  // Random items in blocks that lean toward filling or draining the queue, or balance the two
  function automatic void add_random_items(int unsigned count);
    int unsigned n;
    int unsigned enq_pct;
    logic        op;
    logic [1:0]  prio;
    enq_pct = 50;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 92;
        endcase
      end
      op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
      if (op == spq_pkg::OP_ENQUEUE && $urandom_range(0, 19) != 0)
        prio = 2'($urandom_range(1, 3));
      else
        prio = 2'($urandom_range(0, 3));
      add_item(op, prio, TAG_BITS'($urandom_range(0, 255)));
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Drive items: predict on accept, then offer the next one or idle
  queue_req_t  cur_item;
  int unsigned tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(queue_step(cur_item));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && pending_items.size() != 0 && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          operation    <= cur_item.op;
          priority_req <= cur_item.prio;
          tag          <= cur_item.tg;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: long holds on request, random bursts otherwise
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result against the oldest expectation
  queue_resp_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d prio=%0d tag=%02h occ=%0d",
                   $realtime, status, out_priority, out_tag, occupancy);
      end else begin
        want = results_due.pop_front();
        if (status !== want.st || out_priority !== want.prio ||
            out_tag !== want.tg || occupancy !== want.occ) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected status=%0d prio=%0d tag=%02h occ=%0d",
                     $realtime, want.st, want.prio, want.tg, want.occ);
            $display("%0t:          got      status=%0d prio=%0d tag=%02h occ=%0d",
                     $realtime, status, out_priority, out_tag, occupancy);
          end
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, results_due.size());
      $display("** sorted_priority_queue_top: FAILED **");
      $finish;
    end
  end

  int unsigned k;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty dequeue, bad priority, ordering within and across levels
    add_item(spq_pkg::OP_DEQUEUE, spq_pkg::PRIO_NONE, 8'h00);
    add_item(spq_pkg::OP_ENQUEUE, spq_pkg::PRIO_NONE, 8'h3C);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_LOW,  8'h00);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_HIGH, 8'hFF);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_MID,  8'hAA);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_HIGH, 8'h55);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_LOW,  8'h0F);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_MID,  8'hF0);
    add_item(spq_pkg::OP_ENQUEUE, PRIO_LOW,  8'h81);
    for (k = 0; k < 8; k++)
      add_item(spq_pkg::OP_DEQUEUE, PRIO_HIGH, 8'hFF - 8'(k));
    add_item(spq_pkg::OP_DEQUEUE, PRIO_HIGH, 8'hFF);
    wait_drained();

    // Pressure: hold the receiver for a long stretch and send enqueues past capacity
    holds_asked++;
    for (k = 0; k < 20; k++)
      add_item(spq_pkg::OP_ENQUEUE, 2'($urandom_range(1, 3)),
               TAG_BITS'($urandom_range(0, 255)));
    wait_drained();

    // Sender pauses here until all results are in, then drain past empty
    for (k = 0; k < 17; k++)
      add_item(spq_pkg::OP_DEQUEUE, 2'($urandom_range(0, 3)),
               TAG_BITS'($urandom_range(0, 255)));
    wait_drained();

    // Random traffic with idling on both sides
    add_random_items(1120);
    while (pending_items.size() != 0) @(posedge clk);
    @(negedge clk);

    // Closing stretch at full rate
    idle_on = 1'b0;
    add_random_items(240);
    while (pending_items.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (results_due.size() != 0) fail_count++;
    $display("Run covered %0d items and %0d results, peak occupancy %0d of %0d.",
             items_sent, results_seen, peak_fill, CAPACITY);
    $display("Status counts: full %0d, empty %0d, bad priority %0d; mismatches %0d.",
             full_hits, empty_hits, bad_prio_hits, mismatch_count);
    if (fail_count == 0) begin
      $display("** sorted_priority_queue_top: PASSED **");
    end else begin
      $display("** sorted_priority_queue_top: FAILED **");
    end
    $finish;
  end

endmodule
